// ===== rtl/core/clt_pkg.sv =====
package clt_pkg;

    // field widths of one result item
    localparam int KIND_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int ARGN_W   = 8;
    localparam int OFF_W    = 13;
    localparam int CNT_W    = 9;
    localparam int ERR_W    = 3;

    // configuration register widths and indexes
    localparam int MAX_ARGS_W = 9;
    localparam int BUF_LEN_W  = 17;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_MAX_ARGS   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_BUFFER_LEN = 1'b1;

    localparam logic [MAX_ARGS_W-1:0] MAX_ARGS_RST = 9'd64;
    localparam logic [BUF_LEN_W-1:0]  BUF_LEN_RST  = 17'd1024;

    // results per item and depth of the item queue between front and back
    localparam int MAX_RES     = 3;
    localparam int RES_CNT_W   = 2;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE  = 2'd0,
        KIND_END   = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    typedef enum logic [ERR_W-1:0] {
        ERR_TOO_MANY_ARGS  = 3'd0,
        ERR_BUFFER_FULL    = 3'd1,
        ERR_EOF_BUFFER     = 3'd2,
        ERR_NUL_HIGH_DIGIT = 3'd3,
        ERR_NUL_LOW_DIGIT  = 3'd4,
        ERR_BAD_FIRST_HEX  = 3'd5,
        ERR_BAD_SECOND_HEX = 3'd6
    } t_err;

    typedef enum logic [1:0] {
        HEX_NONE = 2'd0,
        HEX_HIGH = 2'd1,
        HEX_LOW  = 2'd2
    } t_hex;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] byte_out;
        logic [ARGN_W-1:0] arg_number;
        logic              arg_start;
        logic [OFF_W-1:0]  offset;
        logic [CNT_W-1:0]  arg_count;
        t_err              error_code;
        logic              end_of_run;
    } t_result;

    // all results caused by one input item, oldest in slot 0
    typedef struct packed {
        logic [RES_CNT_W-1:0]    count;
        t_result [MAX_RES-1:0]   res;
    } t_bundle;

endpackage

// ===== rtl/core/clt_front.sv =====
module clt_front #(
    parameter int MAX_INPUT_LEN = 4096,
    parameter int ARGS_LIMIT    = 256,
    parameter int BUF_LIMIT     = 65536
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic [7:0]                        i_ch,
    input  logic                              i_last,
    input  logic                              i_cfg_we,
    input  logic [clt_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [clt_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output logic                              o_q_push,
    output clt_pkg::t_bundle                  o_q_bundle
);

    localparam int PW = $clog2(MAX_INPUT_LEN + 1);
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_INPUT_LEN);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_X     = 8'h78;

    // hex digit decode: valid flag over the 4-bit value
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

    // configuration registers
    logic [clt_pkg::MAX_ARGS_W-1:0] r_max_args;
    logic [clt_pkg::BUF_LEN_W-1:0]  r_buffer_len;

    // command state
    logic                          r_esc, n_esc;
    logic                          r_quote, n_quote;
    logic                          r_infield, n_infield;
    logic                          r_argopen, n_argopen;
    clt_pkg::t_hex                 r_hexph, n_hexph;
    logic [3:0]                    r_hexhi, n_hexhi;
    logic                          r_hexbad, n_hexbad;
    logic [clt_pkg::CNT_W-1:0]     r_argtot, n_argtot;
    logic [clt_pkg::BUF_LEN_W-1:0] r_used, n_used;
    logic [PW-1:0]                 r_pos, n_pos;
    logic                          r_disc, n_disc;

    // classification of the item
    logic                          a_add;
    logic [7:0]                    a_val;
    logic [PW-1:0]                 a_pos;
    logic                          a_err;
    clt_pkg::t_err                 a_code;
    logic                          a_end;
    logic [PW-1:0]                 a_end_pos;
    logic                          a_sep;
    logic [4:0]                    hex_d;
    logic [PW-1:0]                 p_inc;

    // argument store bookkeeping
    logic [clt_pkg::BUF_LEN_W-1:0] eb;
    logic [clt_pkg::CNT_W-1:0]     ea;
    logic                          room;
    logic                          slot_ok;
    logic                          b_ok;
    logic                          b_start;
    logic                          b_err;
    clt_pkg::t_err                 b_code;
    logic                          argopen1;
    logic [clt_pkg::CNT_W-1:0]     argtot1;
    logic [clt_pkg::BUF_LEN_W-1:0] used1;
    logic                          err_any;
    clt_pkg::t_err                 err_code;
    logic                          fin;
    logic                          ended_all;
    logic                          close_fire;
    logic [PW-1:0]                 close_pos;
    logic [clt_pkg::RES_CNT_W-1:0] k;
    clt_pkg::t_bundle              bundle;

    // effective limits
    assign eb = ({15'd0, r_buffer_len} > 32'(BUF_LIMIT)) ?
                clt_pkg::BUF_LEN_W'(BUF_LIMIT) : r_buffer_len;
    assign ea = ({23'd0, r_max_args} > 32'(ARGS_LIMIT)) ?
                clt_pkg::CNT_W'(ARGS_LIMIT) : r_max_args;

    assign p_inc = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
    assign hex_d = hex_decode(i_ch);

    // classify the byte against escape, hex and quoting state
    always_comb begin
        n_esc     = r_esc;
        n_quote   = r_quote;
        n_infield = r_infield;
        n_hexph   = r_hexph;
        n_hexhi   = r_hexhi;
        n_hexbad  = r_hexbad;
        a_add     = 1'b0;
        a_val     = i_ch;
        a_pos     = r_pos;
        a_err     = 1'b0;
        a_code    = clt_pkg::ERR_TOO_MANY_ARGS;
        a_end     = 1'b0;
        a_end_pos = r_pos;
        a_sep     = 1'b0;
        case (r_hexph)
            clt_pkg::HEX_HIGH: begin
                if (i_last) begin
                    a_err  = 1'b1;
                    a_code = clt_pkg::ERR_EOF_BUFFER;
                end else if (i_ch == CH_NUL) begin
                    a_err  = 1'b1;
                    a_code = clt_pkg::ERR_NUL_HIGH_DIGIT;
                end else begin
                    n_hexhi  = hex_d[4] ? hex_d[3:0] : 4'd0;
                    n_hexbad = !hex_d[4];
                    n_hexph  = clt_pkg::HEX_LOW;
                end
            end
            clt_pkg::HEX_LOW: begin
                n_hexph = clt_pkg::HEX_NONE;
                if (i_ch == CH_NUL) begin
                    a_err  = 1'b1;
                    a_code = clt_pkg::ERR_NUL_LOW_DIGIT;
                end else if (r_hexbad) begin
                    a_err  = 1'b1;
                    a_code = clt_pkg::ERR_BAD_FIRST_HEX;
                end else if (!hex_d[4]) begin
                    a_err  = 1'b1;
                    a_code = clt_pkg::ERR_BAD_SECOND_HEX;
                end else begin
                    a_add = 1'b1;
                    a_val = {r_hexhi, hex_d[3:0]};
                    a_pos = (r_pos >= PW'(2)) ? r_pos - PW'(2) : '0;
                end
            end
            default: begin
                if (i_ch == CH_NUL) begin
                    a_end = 1'b1;
                end else if (r_esc) begin
                    n_esc     = 1'b0;
                    n_infield = 1'b1;
                    case (i_ch)
                        CH_N:    begin a_add = 1'b1; a_val = CH_LF;  end
                        CH_R:    begin a_add = 1'b1; a_val = CH_CR;  end
                        CH_T:    begin a_add = 1'b1; a_val = CH_TAB; end
                        CH_B:    begin a_add = 1'b1; a_val = CH_BS;  end
                        CH_ZERO: begin a_add = 1'b1; a_val = CH_NUL; end
                        CH_X: begin
                            if (i_last) begin
                                a_err  = 1'b1;
                                a_code = clt_pkg::ERR_EOF_BUFFER;
                            end else begin
                                n_hexph = clt_pkg::HEX_HIGH;
                            end
                        end
                        default: a_add = 1'b1;
                    endcase
                end else begin
                    case (i_ch)
                        CH_BSL:   n_esc = 1'b1;
                        CH_QUOTE: n_quote = !r_quote;
                        CH_HASH: begin
                            if (r_quote) begin
                                n_infield = 1'b1;
                                a_add     = 1'b1;
                            end else begin
                                a_end     = 1'b1;
                                a_end_pos = p_inc;
                            end
                        end
                        CH_SPACE, CH_TAB, CH_CR, CH_LF: begin
                            if (r_quote) begin
                                n_infield = 1'b1;
                                a_add     = 1'b1;
                            end else if (r_infield) begin
                                n_infield = 1'b0;
                                a_sep     = 1'b1;
                            end
                        end
                        default: begin
                            n_infield = 1'b1;
                            a_add     = 1'b1;
                        end
                    endcase
                end
            end
        endcase
    end

    // store one argument byte, opening an argument where needed
    assign room    = ({1'b0, r_used} + 18'd1) < {1'b0, eb};
    assign slot_ok = ({1'b0, r_argtot} + 10'd1) < {1'b0, ea};

    always_comb begin
        b_ok     = 1'b0;
        b_start  = 1'b0;
        b_err    = 1'b0;
        b_code   = clt_pkg::ERR_TOO_MANY_ARGS;
        argopen1 = r_argopen;
        argtot1  = r_argtot;
        used1    = r_used;
        if (a_add) begin
            if (!room) begin
                b_err  = 1'b1;
                b_code = clt_pkg::ERR_BUFFER_FULL;
            end else if (!r_argopen && !slot_ok) begin
                b_err  = 1'b1;
                b_code = clt_pkg::ERR_TOO_MANY_ARGS;
            end else begin
                b_ok     = 1'b1;
                b_start  = !r_argopen;
                argopen1 = 1'b1;
                argtot1  = r_argopen ? r_argtot : r_argtot + 1'b1;
                used1    = r_used + 1'b1;
            end
        end
    end

    // end of argument and end of command
    assign err_any    = a_err || b_err;
    assign err_code   = a_err ? a_code : b_code;
    assign fin        = !err_any && (a_end || i_last);
    assign ended_all  = err_any || a_end || i_last;
    assign close_fire = !err_any && (a_sep || fin) && argopen1;
    assign close_pos  = a_sep ? r_pos : (a_end ? a_end_pos : p_inc);

    // assemble the results of this item in order
    always_comb begin
        bundle = '0;
        k      = '0;
        if (err_any) begin
            bundle.res[0].kind       = clt_pkg::KIND_ERROR;
            bundle.res[0].error_code = err_code;
            bundle.res[0].end_of_run = 1'b1;
            bundle.count             = 2'd1;
        end else begin
            if (b_ok) begin
                bundle.res[k].kind       = clt_pkg::KIND_BYTE;
                bundle.res[k].byte_out   = a_val;
                bundle.res[k].arg_number = clt_pkg::ARGN_W'(argtot1 - 1'b1);
                bundle.res[k].arg_start  = b_start;
                bundle.res[k].offset     = b_start ? clt_pkg::OFF_W'(a_pos) : '0;
                bundle.res[k].end_of_run = !close_fire && !fin;
                k = k + 1'b1;
            end
            if (close_fire) begin
                bundle.res[k].kind       = clt_pkg::KIND_END;
                bundle.res[k].arg_number = clt_pkg::ARGN_W'(argtot1 - 1'b1);
                bundle.res[k].offset     = clt_pkg::OFF_W'(close_pos);
                bundle.res[k].end_of_run = !fin;
                k = k + 1'b1;
            end
            if (fin) begin
                bundle.res[k].kind       = clt_pkg::KIND_DONE;
                bundle.res[k].arg_count  = argtot1;
                bundle.res[k].end_of_run = 1'b1;
                k = k + 1'b1;
            end
            bundle.count = k;
        end
    end

    assign o_q_push   = i_accept && !r_disc && (bundle.count != '0);
    assign o_q_bundle = bundle;

    // next command state
    always_comb begin
        n_argopen = r_argopen;
        n_argtot  = r_argtot;
        n_used    = r_used;
        n_pos     = r_pos;
        n_disc    = r_disc;
        if (r_disc) begin
            n_disc = !i_last;
        end else begin
            n_argopen = argopen1 && !close_fire;
            n_argtot  = argtot1;
            n_used    = close_fire ? used1 + 1'b1 : used1;
            if (ended_all) begin
                n_disc = 1'b1;
            end else begin
                n_pos = p_inc;
            end
        end
    end

    // state registers; the last byte of an ended command clears everything
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last && (r_disc || ended_all))) begin
            r_esc     <= 1'b0;
            r_quote   <= 1'b0;
            r_infield <= 1'b0;
            r_argopen <= 1'b0;
            r_hexph   <= clt_pkg::HEX_NONE;
            r_hexhi   <= 4'd0;
            r_hexbad  <= 1'b0;
            r_argtot  <= '0;
            r_used    <= '0;
            r_pos     <= '0;
            r_disc    <= 1'b0;
        end else if (i_accept && !r_disc) begin
            r_esc     <= n_esc;
            r_quote   <= n_quote;
            r_infield <= n_infield;
            r_argopen <= n_argopen;
            r_hexph   <= n_hexph;
            r_hexhi   <= n_hexhi;
            r_hexbad  <= n_hexbad;
            r_argtot  <= n_argtot;
            r_used    <= n_used;
            r_pos     <= n_pos;
            r_disc    <= n_disc;
        end else if (i_accept) begin
            r_disc <= n_disc;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_args   <= clt_pkg::MAX_ARGS_RST;
            r_buffer_len <= clt_pkg::BUF_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                clt_pkg::REG_MAX_ARGS:   r_max_args   <= i_cfg_wdata[clt_pkg::MAX_ARGS_W-1:0];
                clt_pkg::REG_BUFFER_LEN: r_buffer_len <= i_cfg_wdata[clt_pkg::BUF_LEN_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/core/clt_queue.sv =====
module clt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  clt_pkg::t_bundle i_bundle,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output clt_pkg::t_bundle o_head
);

    localparam int AW = $clog2(clt_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(clt_pkg::QUEUE_DEPTH + 1);

    clt_pkg::t_bundle r_mem [clt_pkg::QUEUE_DEPTH];
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;

    assign o_full  = (r_count == CW'(clt_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];

    // item storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_bundle;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == AW'(clt_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == AW'(clt_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/core/clt_back.sv =====
module clt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_head_valid,
    input  clt_pkg::t_bundle i_head,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output clt_pkg::t_result o_result
);

    logic [clt_pkg::RES_CNT_W-1:0] r_idx;
    logic                          last_slot;
    logic                          take;

    // walk through the results of the head item one at a time
    assign o_empty   = !i_head_valid;
    assign o_result  = i_head.res[r_idx];
    assign take      = i_pop && i_head_valid;
    assign last_slot = (r_idx == i_head.count - 1'b1);
    assign o_q_pop   = take && last_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (take) begin
            r_idx <= last_slot ? '0 : r_idx + 1'b1;
        end
    end

endmodule

// ===== rtl/core/command_line_tokenizer.sv =====
// order: an accepted item's results are built combinationally and registered into the queue, the back reads the head
// throughput: one byte per cycle while full is low; a byte with several results takes one pop
// per result at the back, and a queue of four items between front and back absorbs that
// reset: synchronous, active low; clears command state and the queue, and sets
// max_args to 64 and buffer_len to 1024
module command_line_tokenizer #(
    parameter int MAX_INPUT_LEN = 4096,
    parameter int ARGS_LIMIT    = 256,
    parameter int BUF_LIMIT     = 65536
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     i_ch,
    input  logic                           i_last,
    output logic                           empty,
    input  logic                           pop,
    output logic [clt_pkg::KIND_W-1:0]     o_kind,
    output logic [clt_pkg::BYTE_W-1:0]     o_byte_out,
    output logic [clt_pkg::ARGN_W-1:0]     o_arg_number,
    output logic                           o_arg_start,
    output logic [clt_pkg::OFF_W-1:0]      o_offset,
    output logic [clt_pkg::CNT_W-1:0]      o_arg_count,
    output logic [clt_pkg::ERR_W-1:0]      o_error_code,
    output logic                           o_end_of_run,
    input  logic                           i_cfg_we,
    input  logic [clt_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [clt_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    logic             accept;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;
    clt_pkg::t_bundle q_in;
    clt_pkg::t_bundle q_head;
    clt_pkg::t_result result;

    assign accept = push && !q_full;
    assign full   = q_full;

    // front: classify bytes and build the results of each item
    clt_front #(
        .MAX_INPUT_LEN (MAX_INPUT_LEN),
        .ARGS_LIMIT    (ARGS_LIMIT),
        .BUF_LIMIT     (BUF_LIMIT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_ch        (i_ch),
        .i_last      (i_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_q_push    (q_push),
        .o_q_bundle  (q_in)
    );

    // queue of result groups
    clt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_bundle (q_in),
        .o_full   (q_full),
        .i_pop    (q_pop),
        .o_valid  (q_valid),
        .o_head   (q_head)
    );

    // back: hand results out one by one
    clt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head       (q_head),
        .o_q_pop      (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_result     (result)
    );

    assign o_kind       = result.kind;
    assign o_byte_out   = result.byte_out;
    assign o_arg_number = result.arg_number;
    assign o_arg_start  = result.arg_start;
    assign o_offset     = result.offset;
    assign o_arg_count  = result.arg_count;
    assign o_error_code = result.error_code;
    assign o_end_of_run = result.end_of_run;

`ifndef NO_ASSERTIONS
    // queue never written while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("result queue written while full");

    // back only releases an item that is there
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("result queue popped while empty");

    // done and error close the run of an item
    a_final_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_kind == clt_pkg::KIND_DONE || o_kind == clt_pkg::KIND_ERROR))
        |-> o_end_of_run)
        else $error("done or error result without end of run");

    // nothing waits right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result pending after reset");
`endif

endmodule
